// ===== sv/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, codes and control bundles of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int COUNT_BITS_DEF = 16;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CFG_W   = 5;

   localparam logic [CFG_W-1:0] ACTIVE_CAP_RESET = 5'd16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index as decoded from paddr[2]
   localparam logic REG_ACTIVE_CAPACITY = 1'b0;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   typedef struct packed {
      logic clear;
      logic load;
      logic issue;
      logic sweep;
      logic decide;
      logic load_rsp;
   } lfu_cmd_type;

   typedef struct packed {
      logic issue_last;
      logic do_sweep;
      logic is_get;
   } lfu_status_type;

endpackage

// ===== sv/lfu_req_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if
// Request channel: one get or put item per handshake.
// ----------------------------------------------------------------------------
interface lfu_req_if;
   import lfu_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic signed [KEY_W-1:0]   key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, operation, key, value, input ready);
   modport sink   (input valid, operation, key, value, output ready);
endinterface

// ===== sv/lfu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfu_rsp_if
// Response channel: hit flag and read value of one get.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
   import lfu_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [VALUE_W-1:0] read_value;

   modport source (output valid, hit, read_value, input ready);
   modport sink   (input valid, hit, read_value, output ready);
endinterface

// ===== sv/lfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: scan pass, decision, update sweep and response handoff.
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lfu_pkg::lfu_cmd_type    cmd,
   input  lfu_pkg::lfu_status_type status
);
   import lfu_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.issue_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = status.do_sweep ? ST_SWEEP : ST_FINISH;
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            cmd.sweep = 1'b1;
            if (status.issue_last) begin
               state_in = ST_SWEEP_END;
            end
         end
         ST_SWEEP_END: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.is_get) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && rsp_valid_ff) |-> rsp_ready)
      else $error("response overwritten while pending");

   // a new item only starts from idle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_SCAN))
      else $error("item start did not enter scan");

endmodule

// ===== sv/lfu_datapath.sv =====
// ----------------------------------------------------------------------------
// lfu_datapath
// Entry memory, valid bits, scan accumulators and read-modify-write sweep.
// ----------------------------------------------------------------------------
module lfu_datapath #(
   parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lfu_pkg::lfu_cmd_type               cmd,
   output lfu_pkg::lfu_status_type            status,
   input  logic                               req_operation,
   input  logic signed [lfu_pkg::KEY_W-1:0]   req_key,
   input  logic signed [lfu_pkg::VALUE_W-1:0] req_value,
   input  logic [lfu_pkg::CFG_W-1:0]          active_cap,
   output logic                               rsp_hit,
   output logic signed [lfu_pkg::VALUE_W-1:0] rsp_read_value
);
   import lfu_pkg::*;

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int USED_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [VALUE_W-1:0]    value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_W-1:0]      rank;
   } entry_type;

   entry_type             mem_ff [CAPACITY];
   entry_type             rd_ff;
   entry_type             wr_word;
   logic                  wr_en;
   logic [CAPACITY-1:0]   valid_ff;

   logic                  op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [VALUE_W-1:0]    val_ff;

   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      pidx_ff;
   logic                  pend_ff;
   logic                  psweep_ff;

   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [IDX_W-1:0]      hit_rank_ff;
   logic [VALUE_W-1:0]    hit_value_ff;
   logic [USED_W-1:0]     used_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic                  vic_found_ff;
   logic [IDX_W-1:0]      vic_idx_ff;
   logic [COUNT_BITS-1:0] vic_count_ff;
   logic [IDX_W-1:0]      vic_rank_ff;

   logic [IDX_W-1:0]      tgt_ff;
   logic [IDX_W-1:0]      thr_ff;
   logic                  touch_ff;
   logic                  age_all_ff;

   logic                  rsp_hit_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;

   logic                  cur_valid;
   logic                  scan_en;
   logic                  full;
   logic                  dec_sweep;
   logic                  dec_touch;
   logic                  dec_age_all;
   logic [IDX_W-1:0]      dec_tgt;
   logic [IDX_W-1:0]      dec_thr;
   logic                  is_tgt;

   assign cur_valid = valid_ff[pidx_ff];
   assign scan_en   = pend_ff && !psweep_ff;
   assign is_tgt    = (pidx_ff == tgt_ff);

   assign status.issue_last = (idx_ff == LAST_IDX);
   assign status.do_sweep   = dec_sweep;
   assign status.is_get     = (op_ff == OP_GET);

   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // full when occupancy reaches min(active_cap, CAPACITY)
   assign full = (32'(used_ff) >= 32'(active_cap)) || (used_ff == USED_W'(CAPACITY));

   always_comb begin
      dec_sweep   = 1'b0;
      dec_touch   = 1'b0;
      dec_age_all = 1'b0;
      dec_tgt     = free_idx_ff;
      dec_thr     = hit_rank_ff;
      if (hit_ff) begin
         dec_sweep = 1'b1;
         dec_touch = 1'b1;
         dec_tgt   = hit_idx_ff;
      end else if (op_ff == OP_PUT && active_cap != '0) begin
         dec_sweep = 1'b1;
         if (full) begin
            dec_tgt = vic_idx_ff;
            dec_thr = vic_rank_ff;
         end else begin
            dec_age_all = 1'b1;
         end
      end
   end

   always_comb begin
      wr_word = rd_ff;
      if (is_tgt) begin
         wr_word.rank = '0;
         if (touch_ff) begin
            if (op_ff == OP_PUT) begin
               wr_word.value = val_ff;
            end
            if (!(&rd_ff.count)) begin
               wr_word.count = rd_ff.count + COUNT_BITS'(1);
            end
         end else begin
            wr_word.key   = key_ff;
            wr_word.value = val_ff;
            wr_word.count = COUNT_BITS'(1);
         end
      end else if (cur_valid && (age_all_ff || rd_ff.rank < thr_ff)) begin
         wr_word.rank = rd_ff.rank + IDX_W'(1);
      end
   end

   assign wr_en = pend_ff && psweep_ff && (is_tgt || cur_valid);

   // entry memory: one read and one write port
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_ff <= mem_ff[idx_ff];
      end
      if (wr_en) begin
         mem_ff[pidx_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         pend_ff   <= 1'b0;
         psweep_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         pend_ff   <= cmd.issue;
         psweep_ff <= cmd.sweep;
         if (cmd.clear || (cmd.issue && status.issue_last)) begin
            idx_ff <= '0;
         end else if (cmd.issue) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (wr_en && is_tgt) begin
            valid_ff[pidx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= idx_ff;
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   // scan accumulators
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
         used_ff       <= '0;
      end else if (scan_en) begin
         if (cur_valid) begin
            used_ff <= used_ff + USED_W'(1);
            if (!hit_ff && rd_ff.key == key_ff) begin
               hit_ff       <= 1'b1;
               hit_idx_ff   <= pidx_ff;
               hit_rank_ff  <= rd_ff.rank;
               hit_value_ff <= rd_ff.value;
            end
            if (!vic_found_ff || rd_ff.count < vic_count_ff ||
                (rd_ff.count == vic_count_ff && rd_ff.rank > vic_rank_ff)) begin
               vic_found_ff <= 1'b1;
               vic_idx_ff   <= pidx_ff;
               vic_count_ff <= rd_ff.count;
               vic_rank_ff  <= rd_ff.rank;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= pidx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         tgt_ff     <= dec_tgt;
         thr_ff     <= dec_thr;
         touch_ff   <= dec_touch;
         age_all_ff <= dec_age_all;
      end
      if (cmd.load_rsp) begin
         rsp_hit_ff   <= hit_ff;
         rsp_value_ff <= hit_ff ? hit_value_ff : MISS_VALUE;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(CAPACITY))
      else $error("occupancy count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      hit_ff |-> valid_ff[hit_idx_ff])
      else $error("key match on an invalid entry");

   assert property (@(posedge clock) disable iff (reset)
      vic_found_ff |-> valid_ff[vic_idx_ff])
      else $error("victim is an invalid entry");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && dec_sweep && !dec_touch && !full) |-> free_found_ff)
      else $error("insert without a free entry");

endmodule

// ===== sv/lfu_cache_table.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value cache with LFU replacement and LRU tie-break among equal counts.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-------------------------------------
//   req_bus | in  | valid/ready       | operation, key, value
//   rsp_bus | out | valid/ready       | hit, read_value (gets only)
//   csr     | in  | APB psel/penable  | active_capacity at byte address 0
//
// An item makes one pass over the entry memory, which has one read and one
// write port, to match and pick a victim; a get miss or a put that does
// nothing ends there. When entries are touched or inserted, a second, read-
// modify-write pass updates ranks. Items are taken one at a time; a finished get
// response waits in an output register while the next item is accepted.
// Synchronous reset clears valid bits, control and active_capacity to 16.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
   parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lfu_req_if.sink                          req_bus,
   lfu_rsp_if.source                        rsp_bus,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lfu_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import lfu_pkg::*;

   lfu_cmd_type       cmd;
   lfu_status_type    status;
   logic [CFG_W-1:0]  active_cap_ff;
   logic              csr_sel;

   assign pready  = 1'b1;
   assign csr_sel = (paddr[2] == REG_ACTIVE_CAPACITY);
   assign prdata  = csr_sel ? CSR_DATA_W'(active_cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cap_ff <= ACTIVE_CAP_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel) begin
         active_cap_ff <= pwdata[CFG_W-1:0];
      end
   end

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lfu_datapath #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_operation  (req_bus.operation),
      .req_key        (req_bus.key),
      .req_value      (req_bus.value),
      .active_cap     (active_cap_ff),
      .rsp_hit        (rsp_bus.hit),
      .rsp_read_value (rsp_bus.read_value)
   );

endmodule

// ===== tb/lfu_cache_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_checker
// Tracks the cache contents from accepted items and register writes, works out
// the hit flag and read value of every get, and compares them in order with
// the responses the table returns. Register reads are compared as well.
// ----------------------------------------------------------------------------
module lfu_cache_checker #(
   parameter int CAPACITY   = lfu_pkg::CAPACITY_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   lfu_req_if                             req_bus,
   lfu_rsp_if                             rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [lfu_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             fail_count,
   output int                             results_pending
);
   import lfu_pkg::*;

   localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
   } lookup_type;

   lookup_type expected_lookups[$];

   logic                  ent_valid [CAPACITY];
   logic [KEY_W-1:0]      ent_key   [CAPACITY];
   logic [VALUE_W-1:0]    ent_value [CAPACITY];
   logic [COUNT_BITS-1:0] ent_count [CAPACITY];
   logic [RANK_W-1:0]     ent_rank  [CAPACITY];
   logic [CFG_W-1:0]      active_cap;
   int                    errors = 0;

   initial begin
      fail_count = 0;
      results_pending = 0;
   end

   // rank 0 is the most recent entry
   function automatic void promote_slot(int s);
      for (int i = 0; i < CAPACITY; i++)
         if (ent_valid[i] && i != s && ent_rank[i] < ent_rank[s])
            ent_rank[i]++;
      ent_rank[s] = '0;
   endfunction

   function automatic void bump_use(int s);
      if (ent_count[s] != '1)
         ent_count[s]++;
      promote_slot(s);
   endfunction

   function automatic int find_slot(logic [KEY_W-1:0] k);
      for (int i = 0; i < CAPACITY; i++)
         if (ent_valid[i] && ent_key[i] == k)
            return i;
      return -1;
   endfunction

   function automatic void predict_access(logic op, logic [KEY_W-1:0] k,
                                          logic [VALUE_W-1:0] v);
      int                s;
      int                slot;
      int                used;
      int                cap;
      logic [RANK_W-1:0] gone_rank;
      lookup_type        res;
      s = find_slot(k);
      slot = -1;
      used = 0;
      if (op == OP_GET) begin
         if (s >= 0) begin
            bump_use(s);
            res.hit = 1'b1;
            res.read_value = ent_value[s];
         end else begin
            res.hit = 1'b0;
            res.read_value = MISS_VALUE;
         end
         expected_lookups.push_back(res);
         return;
      end
      if (s >= 0) begin
         ent_value[s] = v;
         bump_use(s);
         return;
      end
      cap = (int'(active_cap) > CAPACITY) ? CAPACITY : int'(active_cap);
      if (cap == 0)
         return;
      for (int i = 0; i < CAPACITY; i++)
         if (ent_valid[i])
            used++;
      if (used >= cap) begin
         // lowest use count, then least recent
         for (int i = 0; i < CAPACITY; i++)
            if (ent_valid[i] && (slot < 0 || ent_count[i] < ent_count[slot] ||
                (ent_count[i] == ent_count[slot] && ent_rank[i] > ent_rank[slot])))
               slot = i;
         if (slot >= 0) begin
            gone_rank = ent_rank[slot];
            ent_valid[slot] = 1'b0;
            for (int i = 0; i < CAPACITY; i++)
               if (ent_valid[i] && ent_rank[i] > gone_rank)
                  ent_rank[i]--;
         end
      end else begin
         for (int i = 0; i < CAPACITY; i++)
            if (!ent_valid[i]) begin
               slot = i;
               break;
            end
      end
      if (slot < 0)
         return;
      for (int i = 0; i < CAPACITY; i++)
         if (ent_valid[i])
            ent_rank[i]++;
      ent_valid[slot] = 1'b1;
      ent_key[slot]   = k;
      ent_value[slot] = v;
      ent_count[slot] = COUNT_BITS'(1);
      ent_rank[slot]  = '0;
   endfunction

   always @(posedge clock) begin
      lookup_type want;
      if (reset) begin
         expected_lookups.delete();
         active_cap = ACTIVE_CAP_RESET;
         for (int i = 0; i < CAPACITY; i++) begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_value[i] = '0;
            ent_count[i] = '0;
            ent_rank[i]  = '0;
         end
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_lookups.size() == 0) begin
               $error("unexpected item: hit=%0b read_value=%h",
                      rsp_bus.hit, rsp_bus.read_value);
               errors++;
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_bus.hit !== want.hit) begin
                  $error("hit: expected %0b, actual %0b", want.hit, rsp_bus.hit);
                  errors++;
               end
               if (rsp_bus.read_value !== want.read_value) begin
                  $error("read_value: expected %h, actual %h",
                         want.read_value, rsp_bus.read_value);
                  errors++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            predict_access(req_bus.operation, req_bus.key, req_bus.value);
         if (psel && penable && pready && (paddr >> 2) == REG_ACTIVE_CAPACITY) begin
            if (pwrite) begin
               active_cap = pwdata[CFG_W-1:0];
            end else if (prdata !== CSR_DATA_W'(active_cap)) begin
               $error("active_capacity: expected %0d, actual %0d", active_cap, prdata);
               errors++;
            end
         end
      end
      fail_count <= errors;
      results_pending <= expected_lookups.size();
   end

endmodule

// ===== tb/lfu_cache_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_test
// Drives gets and puts into the LFU cache table in bursts, with the response
// side stalling at random, and steps active_capacity through empty, tiny,
// lowered and oversized settings. A directed sequence covers key and value
// extremes, updates, eviction ties and the zero capacity case first.
// ----------------------------------------------------------------------------
module lfu_cache_table_test;
   import lfu_pkg::*;

   localparam int SLOTS         = 16;
   localparam int COUNT_W       = COUNT_BITS_DEF;
   localparam int SETTLE_CYCLES = 2 * SLOTS + 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int POOL_N        = 24;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 85;

   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR    = {REG_ACTIVE_CAPACITY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = {~REG_ACTIVE_CAPACITY, 2'b00};

   localparam int PHASE_CAP   [PHASES] = '{3, 0, 31, 1, 16, 7, 17, 12};
   localparam int PHASE_GAP   [PHASES] = '{0, 6, 40, 0, 8, 3, 0, 20};
   localparam int PHASE_STALL [PHASES] = '{30, 0, 75, 10, 0, 50, 30, 0};

   logic clock = 1'b0;
   logic reset;

   lfu_req_if req_if ();
   lfu_rsp_if rsp_if ();

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int results_pending;
   int stall_pct = 0;
   int stall_max = 0;
   int stall_left = 0;
   int gap_max = 0;
   int idle_cycles = 0;

   logic [KEY_W-1:0] key_pool [POOL_N];

   always #1 clock = ~clock;

   lfu_cache_table #(.CAPACITY(SLOTS), .COUNT_BITS(COUNT_W)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   lfu_cache_checker #(.CAPACITY(SLOTS), .COUNT_BITS(COUNT_W)) cache_check (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_if),
      .rsp_bus         (rsp_if),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .results_pending (results_pending)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(99) < stall_pct) begin
         rsp_if.ready <= 1'b0;
         stall_left <= $urandom_range(stall_max);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // leaves valid high so a back-to-back item needs no second assignment
   task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.key <= k;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(posedge clock);
      while (results_pending != 0)
         @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [CSR_ADDR_W-1:0] addr,
                             logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // table must be idle: puts give no item back, so let the last one finish
   task automatic reconfigure(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      req_if.valid <= 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, addr, data);
      csr_access(1'b0, CAP_ADDR, '0);
   endtask

   task automatic run_phase(int n_items, int pool_n);
      int               sent;
      int               burst;
      logic             op;
      logic [KEY_W-1:0] k;
      logic             pause;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent < n_items) begin
            op = 1'($urandom_range(1));
            if ($urandom_range(9) < 7)
               k = key_pool[$urandom_range($urandom_range(pool_n - 1))];
            else
               k = $urandom;
            send_item(op, k, $urandom);
            sent++;
            burst--;
         end
         pause = ($urandom_range(29) == 0);
         if (gap_max > 0 || pause) begin
            req_if.valid <= 1'b0;
            if (gap_max > 0)
               repeat ($urandom_range(1, gap_max)) @(posedge clock);
            if (pause)
               wait_for_results();
         end
      end
   endtask

   initial begin
      int cap;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.operation <= OP_GET;
      req_if.key <= '0;
      req_if.value <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_N; i++)
         key_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      stall_pct <= 20;
      stall_max <= 4;

      send_item(OP_GET, 32'h0, 32'h0);
      send_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(OP_PUT, 32'h0, 32'h0);
      send_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_GET, 32'h8000_0000, 32'h0);
      send_item(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_GET, 32'h0, 32'h0);
      send_item(OP_GET, 32'h5, 32'h0);
      send_item(OP_PUT, 32'h0, 32'h1234_5678);
      send_item(OP_GET, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_GET, 32'h7FFF_FFFF, 32'h0);

      // below occupancy: one put evicts the older of the two tied entries
      reconfigure(CAP_ADDR, 3);
      send_item(OP_PUT, 32'h1, 32'h1);
      send_item(OP_GET, 32'h8000_0000, 32'h0);
      send_item(OP_GET, 32'hFFFF_FFFF, 32'h0);

      reconfigure(CAP_ADDR, 0);
      send_item(OP_PUT, 32'h2, 32'h2);
      send_item(OP_GET, 32'h2, 32'h0);
      send_item(OP_PUT, 32'h0, 32'h7);
      send_item(OP_GET, 32'h0, 32'h0);

      reconfigure(UNUSED_ADDR, 16);
      reconfigure(CAP_ADDR, 31);
      send_item(OP_PUT, 32'h3, 32'hA5A5_5A5A);
      send_item(OP_GET, 32'h3, 32'h0);

      for (int p = 0; p < PHASES; p++) begin
         reconfigure(CAP_ADDR, PHASE_CAP[p]);
         gap_max <= PHASE_GAP[p];
         stall_pct <= PHASE_STALL[p];
         stall_max <= (p % 2 == 0) ? 12 : 3;
         cap = (PHASE_CAP[p] > SLOTS) ? SLOTS : PHASE_CAP[p];
         run_phase(PHASE_ITEMS, cap + 4);
      end

      req_if.valid <= 1'b0;
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/lfu_pkg.sv
sv/lfu_req_if.sv
sv/lfu_rsp_if.sv
sv/lfu_ctrl.sv
sv/lfu_datapath.sv
sv/lfu_cache_table.sv
tb/lfu_cache_checker.sv
tb/lfu_cache_table_test.sv
